// ===== sv/pct_pkg.sv =====
`default_nettype none

package pct_pkg;

    // gray verdict codes
    typedef enum logic [1:0] {
        GRAY_WITHIN = 2'd0,
        GRAY_BELOW  = 2'd1,
        GRAY_ABOVE  = 2'd2
    } gray_verdict_t;

    // hue verdict codes
    typedef enum logic [1:0] {
        HUE_OK     = 2'd0,
        HUE_ACHROM = 2'd1,
        HUE_BELOW  = 2'd2,
        HUE_ABOVE  = 2'd3
    } hue_verdict_t;

    // which 120 degree sector the hue starts from; red wrap is the 360 sector
    typedef enum logic [1:0] {
        SEG_RED      = 2'd0,
        SEG_GREEN    = 2'd1,
        SEG_BLUE     = 2'd2,
        SEG_RED_WRAP = 2'd3
    } hue_seg_t;

    // register word indexes on the config port
    localparam logic REG_GRAY_TOL = 1'b0;
    localparam logic REG_HUE_TOL  = 1'b1;

    localparam int unsigned QUOT_W      = 16;
    localparam int unsigned NUM_W       = 25;
    localparam int unsigned DIV_STEPS   = 4;
    localparam int unsigned DIV_STAGES  = QUOT_W / DIV_STEPS;
    localparam int unsigned NUM_STAGES  = DIV_STAGES + 4;
    localparam int unsigned PROD_W      = 29;
    localparam int unsigned RECIP_SHIFT = 19;

    // hundredths of a degree per sector and per half sector
    localparam logic [23:0] SECTOR_HUNDREDTHS = 24'd12000;
    localparam logic signed [25:0] HALF_SECTOR_HUNDREDTHS = 26'sd6000;
    // x / 100 == (x * RECIP_100) >> RECIP_SHIFT for every quotient below 36000
    localparam logic [12:0] RECIP_100 = 13'd5243;

    localparam logic signed [10:0] DEG_FULL   = 11'sd360;
    localparam logic signed [10:0] DEG_DOUBLE = 11'sd720;
    localparam logic signed [10:0] DEG_HALF   = 11'sd180;
    localparam logic [7:0] HUE_TOL_WIDE = 8'd180;

    typedef struct packed {
        hue_seg_t    seg;
        logic [7:0]  span;
        logic [8:0]  side;
        logic        achrom;
    } hue_prep_t;

    typedef struct packed {
        logic [8:0]        rem;
        logic [QUOT_W-1:0] bits;
        logic [8:0]        dvs;
        logic              achrom;
    } hue_div_t;

endpackage

`default_nettype wire

// ===== sv/pixel_color_tolerance_check.sv =====
`default_nettype none

// channel | direction | handshake          | payload
// in      | to block  | in_valid/in_stall   | cand_red..blue, ref_red..blue
// out     | from block| out_valid/out_stall | gray_verdict, hue_verdict, match
// cfg     | to block  | apb psel/penable    | gray_tolerance @0, hue_half_tolerance @4
//
// one item per clock while the output is not stalled
// the depth is set by the hue divider: 16 quotient bits, 4 per stage
// reset clears valid bits and both tolerance registers
// a stalled output freezes the whole pipeline, so in_stall follows it

module pixel_color_tolerance_check (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         in_valid,
    output logic        in_stall,
    input  wire  [7:0]  cand_red,
    input  wire  [7:0]  cand_green,
    input  wire  [7:0]  cand_blue,
    input  wire  [7:0]  ref_red,
    input  wire  [7:0]  ref_green,
    input  wire  [7:0]  ref_blue,
    output logic        out_valid,
    input  wire         out_stall,
    output logic [1:0]  gray_verdict,
    output logic [1:0]  hue_verdict,
    output logic        match,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    import pct_pkg::*;

    function automatic logic [7:0] gray_of(input logic [7:0] r, input logic [7:0] g,
                                           input logic [7:0] b);
        logic [12:0] sum;
        sum = {5'b00000, r} * 13'd11 + {1'b0, g, 4'b0000} + {5'b00000, b} * 13'd5;
        return sum[12:5];
    endfunction

    function automatic hue_prep_t prep_pixel(input logic [7:0] r, input logic [7:0] g,
                                             input logic [7:0] b);
        logic [7:0] mx;
        logic [7:0] mn;
        hue_prep_t  p;
        mx = r;
        mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        p.span   = mx - mn;
        p.achrom = (mx == mn);
        if (r == mx)
        begin
            p.side = {1'b0, g} - {1'b0, b};
            p.seg  = (g < b) ? SEG_RED_WRAP : SEG_RED;
        end
        else if (g == mx)
        begin
            p.side = {1'b0, b} - {1'b0, r};
            p.seg  = SEG_GREEN;
        end
        else
        begin
            p.side = {1'b0, r} - {1'b0, g};
            p.seg  = SEG_BLUE;
        end
        return p;
    endfunction

    // numerator 2n + d and divisor 2d of the rounded hue in hundredths
    function automatic hue_div_t make_div(input hue_prep_t p);
        logic [9:0]          seg_span;
        logic [23:0]         base_n;
        logic signed [25:0]  side_n;
        logic signed [25:0]  n;
        logic [NUM_W-1:0]    num;
        hue_div_t            x;
        seg_span = {2'b00, p.span} * {8'b00000000, p.seg};
        base_n   = {14'b0, seg_span} * SECTOR_HUNDREDTHS;
        side_n   = $signed({{17{p.side[8]}}, p.side}) * HALF_SECTOR_HUNDREDTHS;
        n        = $signed({2'b00, base_n}) + side_n;
        num      = {n[23:0], 1'b0} + {17'b0, p.span};
        x.rem    = num[NUM_W-1:QUOT_W];
        x.bits   = num[QUOT_W-1:0];
        x.dvs    = {p.span, 1'b0};
        x.achrom = p.achrom;
        return x;
    endfunction

    // restoring division: numerator bits shift out at the top, quotient bits in at the bottom
    function automatic hue_div_t div_run(input hue_div_t x);
        logic [9:0] trial;
        logic       qb;
        hue_div_t   y;
        y = x;
        for (int k = 0; k < DIV_STEPS; k++)
        begin
            trial = {y.rem, y.bits[QUOT_W-1]};
            if (trial >= {1'b0, y.dvs})
            begin
                y.rem = 9'(trial - {1'b0, y.dvs});
                qb    = 1'b1;
            end
            else
            begin
                y.rem = trial[8:0];
                qb    = 1'b0;
            end
            y.bits = {y.bits[QUOT_W-2:0], qb};
        end
        return y;
    endfunction

    function automatic hue_verdict_t hue_classify(input logic ach_c, input logic [8:0] deg_c,
                                                  input logic ach_r, input logic [8:0] deg_r,
                                                  input logic [7:0] t);
        logic signed [10:0] h;
        logic signed [10:0] hr;
        logic signed [10:0] ts;
        logic signed [10:0] lo;
        logic signed [10:0] hi;
        logic               inv;
        hue_verdict_t       v;
        h  = ach_c ? -11'sd1 : $signed({2'b00, deg_c});
        hr = ach_r ? -11'sd1 : $signed({2'b00, deg_r});
        ts = $signed({3'b000, t});
        lo = hr - ts + DEG_FULL;
        if (lo >= DEG_FULL) lo = lo - DEG_FULL;
        hi = hr + ts + DEG_FULL;
        if (hi >= DEG_DOUBLE)
            hi = hi - DEG_DOUBLE;
        else if (hi >= DEG_FULL)
            hi = hi - DEG_FULL;
        inv = lo > hi;
        if (ach_c != ach_r)
            v = HUE_ACHROM;
        else if (t >= HUE_TOL_WIDE)
            v = HUE_OK;
        else if (h < lo && (!inv || h >= DEG_HALF))
            v = HUE_BELOW;
        else if (h > hi && (!inv || h <= DEG_HALF))
            v = HUE_ABOVE;
        else
            v = HUE_OK;
        return v;
    endfunction

    // config registers
    logic [7:0] gray_tol_reg;
    logic [7:0] hue_tol_reg;
    logic [7:0] gray_tol_next;
    logic [7:0] hue_tol_next;
    logic       cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        gray_tol_next = gray_tol_reg;
        hue_tol_next  = hue_tol_reg;
        if (cfg_write)
        begin
            case (paddr[2])
                REG_GRAY_TOL: gray_tol_next = pwdata[7:0];
                REG_HUE_TOL:  hue_tol_next  = pwdata[7:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_GRAY_TOL: prdata = {24'b0, gray_tol_reg};
            REG_HUE_TOL:  prdata = {24'b0, hue_tol_reg};
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gray_tol_reg <= '0;
            hue_tol_reg  <= '0;
        end
        else
        begin
            gray_tol_reg <= gray_tol_next;
            hue_tol_reg  <= hue_tol_next;
        end
    end

    // pipeline control
    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic                  adv;

    assign adv        = !(valid_reg[NUM_STAGES-1] && out_stall);
    assign in_stall   = !adv;
    assign valid_next = {valid_reg[NUM_STAGES-2:0], in_valid};
    assign out_valid  = valid_reg[NUM_STAGES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (adv)
            valid_reg <= valid_next;
    end

    // lane 0 is the candidate pixel, lane 1 the reference pixel
    hue_prep_t [1:0] prep_next;
    hue_prep_t [1:0] prep_reg;
    logic [7:0]      gray_c_next;
    logic [7:0]      gray_r_next;
    logic [7:0]      gray_c_reg;
    logic [7:0]      gray_r_reg;

    hue_div_t [1:0]  div_next [0:DIV_STAGES];
    hue_div_t [1:0]  div_reg  [0:DIV_STAGES];
    gray_verdict_t   gv_next  [0:DIV_STAGES];
    gray_verdict_t   gv_reg   [0:DIV_STAGES];

    logic [1:0][PROD_W-1:0] prod_next;
    logic [1:0][PROD_W-1:0] prod_reg;
    logic [1:0]             prod_ach_reg;
    gray_verdict_t          prod_gv_reg;

    gray_verdict_t          gray_verdict_next;
    gray_verdict_t          gray_verdict_reg;
    hue_verdict_t           hue_verdict_next;
    hue_verdict_t           hue_verdict_reg;
    logic                   match_next;
    logic                   match_reg;

    // stage a: extremes, sector and gray sums
    always_comb
    begin
        prep_next[0] = prep_pixel(cand_red, cand_green, cand_blue);
        prep_next[1] = prep_pixel(ref_red, ref_green, ref_blue);
        gray_c_next  = gray_of(cand_red, cand_green, cand_blue);
        gray_r_next  = gray_of(ref_red, ref_green, ref_blue);
    end

    // stage b: hue numerator and gray verdict
    always_comb
    begin
        div_next[0][0] = make_div(prep_reg[0]);
        div_next[0][1] = make_div(prep_reg[1]);
        if (({1'b0, gray_c_reg} + {1'b0, gray_tol_reg}) < {1'b0, gray_r_reg})
            gv_next[0] = GRAY_BELOW;
        else if ({1'b0, gray_c_reg} > ({1'b0, gray_r_reg} + {1'b0, gray_tol_reg}))
            gv_next[0] = GRAY_ABOVE;
        else
            gv_next[0] = GRAY_WITHIN;
    end

    for (genvar gs = 1; gs <= DIV_STAGES; gs++)
    begin : g_div
        always_comb
        begin
            div_next[gs][0] = div_run(div_reg[gs-1][0]);
            div_next[gs][1] = div_run(div_reg[gs-1][1]);
            gv_next[gs]     = gv_reg[gs-1];
        end
    end

    // scale hundredths to whole degrees
    always_comb
    begin
        prod_next[0] = {{(PROD_W-QUOT_W){1'b0}}, div_reg[DIV_STAGES][0].bits}
                       * {{(PROD_W-13){1'b0}}, RECIP_100};
        prod_next[1] = {{(PROD_W-QUOT_W){1'b0}}, div_reg[DIV_STAGES][1].bits}
                       * {{(PROD_W-13){1'b0}}, RECIP_100};
    end

    always_comb
    begin
        gray_verdict_next = prod_gv_reg;
        hue_verdict_next  = hue_classify(prod_ach_reg[0], prod_reg[0][RECIP_SHIFT+8:RECIP_SHIFT],
                                         prod_ach_reg[1], prod_reg[1][RECIP_SHIFT+8:RECIP_SHIFT],
                                         hue_tol_reg);
        match_next        = (prod_gv_reg == GRAY_WITHIN) && (hue_verdict_next == HUE_OK);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prep_reg     <= prep_next;
            gray_c_reg   <= gray_c_next;
            gray_r_reg   <= gray_r_next;
            for (int s = 0; s <= DIV_STAGES; s++)
            begin
                div_reg[s] <= div_next[s];
                gv_reg[s]  <= gv_next[s];
            end
            prod_reg     <= prod_next;
            prod_ach_reg <= {div_reg[DIV_STAGES][1].achrom, div_reg[DIV_STAGES][0].achrom};
            prod_gv_reg  <= gv_reg[DIV_STAGES];
            gray_verdict_reg <= gray_verdict_next;
            hue_verdict_reg  <= hue_verdict_next;
            match_reg        <= match_next;
        end
    end

    assign gray_verdict = gray_verdict_reg;
    assign hue_verdict  = hue_verdict_reg;
    assign match        = match_reg;

endmodule

`default_nettype wire

// ===== verif/pixel_color_tolerance_check_tb.sv =====
module pixel_color_tolerance_check_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pct_pkg::*;

    localparam int HUE_NONE     = -1;
    localparam int FULL_TURN    = 360;
    localparam int HALF_TURN    = 180;
    localparam int PHASE_ITEMS  = 250;
    localparam int SETTLE       = 12;
    localparam int FIRST_HOLD   = 500;
    localparam int HOLD_SPACING = 700;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct packed {
        logic [7:0] cand_r;
        logic [7:0] cand_g;
        logic [7:0] cand_b;
        logic [7:0] ref_r;
        logic [7:0] ref_g;
        logic [7:0] ref_b;
    } pixel_pair_t;

    typedef struct packed {
        gray_verdict_t gray;
        hue_verdict_t  hue;
        logic          both_ok;
    } verdict_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    wire         in_stall;
    wire         out_valid;
    logic        out_stall = 1'b0;
    wire  [1:0]  gray_verdict;
    wire  [1:0]  hue_verdict;
    wire         match;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    wire  [31:0] prdata;
    wire         pready;

    pixel_pair_t on_offer = '0;
    pixel_pair_t pending_pairs[$];
    verdict_t    awaiting[$];

    int gray_tol_now = 0;
    int hue_tol_now = 0;
    int items_in = 0;
    int results_seen = 0;
    int match_count = 0;
    int fault_count = 0;
    int setting_count = 0;
    int burst_left = 0;
    int gap_left = 0;
    int pattern_left = 0;
    int stall_pct = 0;
    int hold_left = 0;
    int hold_at = FIRST_HOLD;
    int hold_count = 0;
    int cycles = 0;

    pixel_color_tolerance_check uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cand_red     (on_offer.cand_r),
        .cand_green   (on_offer.cand_g),
        .cand_blue    (on_offer.cand_b),
        .ref_red      (on_offer.ref_r),
        .ref_green    (on_offer.ref_g),
        .ref_blue     (on_offer.ref_b),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .gray_verdict (gray_verdict),
        .hue_verdict  (hue_verdict),
        .match        (match),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int gray_level(input logic [7:0] r, input logic [7:0] g,
                                      input logic [7:0] b);
        return (11 * int'(r) + 16 * int'(g) + 5 * int'(b)) / 32;
    endfunction

    // whole degrees, or HUE_NONE when all three components are equal
    function automatic int hue_degrees(input logic [7:0] r, input logic [7:0] g,
                                       input logic [7:0] b);
        int top;
        int bottom;
        int span;
        int num;
        top = int'(r);
        bottom = int'(r);
        if (int'(g) > top) top = int'(g);
        if (int'(b) > top) top = int'(b);
        if (int'(g) < bottom) bottom = int'(g);
        if (int'(b) < bottom) bottom = int'(b);
        span = top - bottom;
        if (span == 0)
            return HUE_NONE;
        if (int'(r) == top)
        begin
            num = 6000 * (int'(g) - int'(b));
            if (g < b)
                num += 36000 * span;
        end
        else if (int'(g) == top)
            num = 12000 * span + 6000 * (int'(b) - int'(r));
        else
            num = 24000 * span + 6000 * (int'(r) - int'(g));
        // hundredths rounded half up, then truncated to degrees
        return ((2 * num + span) / (2 * span)) / 100;
    endfunction

    function automatic hue_verdict_t hue_class(input int cand_hue, input int ref_hue,
                                               input int half_tol);
        int   lo;
        int   hi;
        logic wrapped;
        if ((cand_hue == HUE_NONE) != (ref_hue == HUE_NONE))
            return HUE_ACHROM;
        if (half_tol >= HALF_TURN)
            return HUE_OK;
        lo = (ref_hue - half_tol + FULL_TURN) % FULL_TURN;
        hi = (ref_hue + half_tol + FULL_TURN) % FULL_TURN;
        wrapped = lo > hi;
        // with a window across 0 the half turn decides which side a hue is on
        if (cand_hue < lo && (!wrapped || cand_hue >= HALF_TURN))
            return HUE_BELOW;
        if (cand_hue > hi && (!wrapped || cand_hue <= HALF_TURN))
            return HUE_ABOVE;
        return HUE_OK;
    endfunction

    function automatic verdict_t judge_pair(input pixel_pair_t p, input int gtol,
                                            input int htol);
        verdict_t v;
        int       cand_gray;
        int       ref_gray;
        cand_gray = gray_level(p.cand_r, p.cand_g, p.cand_b);
        ref_gray = gray_level(p.ref_r, p.ref_g, p.ref_b);
        if (cand_gray < ref_gray - gtol)
            v.gray = GRAY_BELOW;
        else if (cand_gray > ref_gray + gtol)
            v.gray = GRAY_ABOVE;
        else
            v.gray = GRAY_WITHIN;
        v.hue = hue_class(hue_degrees(p.cand_r, p.cand_g, p.cand_b),
                          hue_degrees(p.ref_r, p.ref_g, p.ref_b), htol);
        v.both_ok = (v.gray == GRAY_WITHIN) && (v.hue == HUE_OK);
        return v;
    endfunction

    function automatic logic [7:0] nudge(input logic [7:0] v);
        int n;
        n = int'(v) + int'($urandom_range(0, 12)) - 6;
        if (n < 0) n = 0;
        if (n > 255) n = 255;
        return n[7:0];
    endfunction

    function automatic logic [7:0] rail_value();
        return $urandom_range(0, 1) ? 8'hff : 8'h00;
    endfunction

    function automatic pixel_pair_t random_pair();
        pixel_pair_t p;
        int          pick;
        p = 48'({$urandom, $urandom});
        pick = $urandom_range(0, 99);
        if (pick < 40)
        begin
            // candidate close to the reference, so verdicts land near the bounds
            p.cand_r = nudge(p.ref_r);
            p.cand_g = nudge(p.ref_g);
            p.cand_b = nudge(p.ref_b);
        end
        else if (pick < 55)
        begin
            p.cand_g = p.cand_r;
            p.cand_b = p.cand_r;
            if ($urandom_range(0, 1))
            begin
                p.ref_g = p.ref_r;
                p.ref_b = p.ref_r;
            end
        end
        else if (pick < 62)
        begin
            p.ref_g = p.ref_r;
            p.ref_b = p.ref_r;
        end
        else if (pick < 72)
        begin
            p.cand_r = rail_value();
            p.cand_g = rail_value();
            p.cand_b = rail_value();
            p.ref_r = rail_value();
            p.ref_g = rail_value();
            p.ref_b = rail_value();
        end
        return p;
    endfunction

    task automatic report_fault(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        fault_count++;
    endtask

    task automatic write_register(input logic idx, input logic [7:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= ($urandom & 32'hffff_ff00) | 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_GRAY_TOL)
            gray_tol_now = int'(value);
        else
            hue_tol_now = int'(value);
    endtask

    task automatic apply_tolerances(input logic [7:0] gtol, input logic [7:0] htol);
        write_register(REG_GRAY_TOL, gtol);
        write_register(REG_HUE_TOL, htol);
        setting_count++;
    endtask

    task automatic drain();
        do
            @(negedge clk);
        while (pending_pairs.size() != 0 || in_valid || awaiting.size() != 0);
        repeat (SETTLE) @(negedge clk);
    endtask

    // sender: bursts of random length with random gaps
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            burst_left <= 0;
            gap_left <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                awaiting.push_back(judge_pair(on_offer, gray_tol_now, hue_tol_now));
                items_in <= items_in + 1;
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left != 0)
                begin
                    in_valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else if (pending_pairs.size() != 0)
                begin
                    in_valid <= 1'b1;
                    on_offer <= pending_pairs.pop_front();
                    if (burst_left > 1)
                        burst_left <= burst_left - 1;
                    else
                    begin
                        burst_left <= $urandom_range(1, 48);
                        gap_left <= ($urandom_range(0, 9) < 6) ? 0 : $urandom_range(1, 10);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // long hold-off on the output while items keep coming
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_at <= FIRST_HOLD;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (items_in == hold_at)
        begin
            hold_left <= HOLD_CYCLES;
            hold_at <= hold_at + HOLD_SPACING;
            hold_count <= hold_count + 1;
        end
    end

    // receiver stall pattern, changing density every so often
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            pattern_left <= 0;
            stall_pct <= 0;
        end
        else
        begin
            if (pattern_left == 0)
            begin
                pattern_left <= $urandom_range(16, 160);
                case ($urandom_range(0, 4))
                    2: stall_pct <= 25;
                    3: stall_pct <= 50;
                    4: stall_pct <= 85;
                    default: stall_pct <= 0;
                endcase
            end
            else
                pattern_left <= pattern_left - 1;
            out_stall <= (hold_left != 0) || (int'($urandom_range(1, 100)) <= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        verdict_t want;
        if (rst_n && out_valid === 1'b1 && !out_stall)
        begin
            if (awaiting.size() == 0)
                report_fault("result came out with no item waiting for it");
            else
            begin
                want = awaiting.pop_front();
                if (gray_verdict !== want.gray)
                    report_fault($sformatf("result %0d gray verdict %0d, predicted %0d",
                                           results_seen, gray_verdict, want.gray));
                if (hue_verdict !== want.hue)
                    report_fault($sformatf("result %0d hue verdict %0d, predicted %0d",
                                           results_seen, hue_verdict, want.hue));
                if (match !== want.both_ok)
                    report_fault($sformatf("result %0d match %0d, predicted %0d",
                                           results_seen, match, want.both_ok));
                if (want.both_ok)
                    match_count++;
            end
            results_seen++;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, awaiting.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset tolerances are both zero
        setting_count = 1;
        pending_pairs.push_back('{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0});
        pending_pairs.push_back('{8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0});
        pending_pairs.push_back('{8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255});
        pending_pairs.push_back('{8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0});
        pending_pairs.push_back('{8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd0});
        pending_pairs.push_back('{8'd0, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0});
        pending_pairs.push_back('{8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255});
        pending_pairs.push_back('{8'd128, 8'd128, 8'd128, 8'd200, 8'd10, 8'd10});
        pending_pairs.push_back('{8'd200, 8'd10, 8'd10, 8'd128, 8'd128, 8'd128});
        // red just below the wrap against pure red
        pending_pairs.push_back('{8'd255, 8'd0, 8'd8, 8'd255, 8'd0, 8'd0});
        // ties for the largest component
        pending_pairs.push_back('{8'd255, 8'd255, 8'd0, 8'd255, 8'd200, 8'd0});
        pending_pairs.push_back('{8'd0, 8'd255, 8'd255, 8'd0, 8'd200, 8'd255});
        pending_pairs.push_back('{8'd255, 8'd0, 8'd255, 8'd255, 8'd0, 8'd255});
        pending_pairs.push_back('{8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd1});
        pending_pairs.push_back('{8'd3, 8'd2, 8'd0, 8'd3, 8'd2, 8'd0});
        pending_pairs.push_back('{8'd255, 8'd128, 8'd0, 8'd0, 8'd128, 8'd255});
        pending_pairs.push_back('{8'd10, 8'd0, 8'd5, 8'd255, 8'd0, 8'd1});
        drain();

        for (int phase = 0; phase < 7; phase++)
        begin
            case (phase)
                0: apply_tolerances(8'd255, 8'd180);
                1: apply_tolerances(8'd0, 8'd255);
                2: apply_tolerances(8'd255, 8'd0);
                3: apply_tolerances(8'd8, 8'd15);
                4: apply_tolerances(8'd1, 8'd179);
                5: apply_tolerances(8'd40, 8'd90);
                default: apply_tolerances(8'($urandom_range(0, 255)),
                                          8'($urandom_range(0, 180)));
            endcase
            @(negedge clk);
            repeat (PHASE_ITEMS) pending_pairs.push_back(random_pair());
            drain();
        end

        if (awaiting.size() != 0)
            report_fault($sformatf("%0d predicted results never came out", awaiting.size()));
        $display("checked %0d pixel comparisons under %0d tolerance settings, %0d matched",
                 results_seen, setting_count, match_count);
        $display("output held off %0d times while the input kept offering", hold_count);
        if (fault_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
